### rtl/array_literal_parser_macros.svh
// Assertion macros shared by the array literal parser RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ARRAY_LITERAL_PARSER_MACROS_SVH
`define ARRAY_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("array literal parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ALP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("array literal parser check failed");

`endif

### rtl/alp_pkg.sv
// Types, codes and constants of the array literal parser.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps

package alp_pkg;

    localparam int HOLD_DEPTH = 4;
    localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
    localparam int RAW_CNT_W  = 3;
    localparam logic [RAW_CNT_W-1:0] RAW_SAT = '1;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
    localparam int RES_CNT_W  = 3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CASE_FOLD = 8'h20;

    typedef enum logic [1:0] {
        K_DATA = 2'd0,
        K_END  = 2'd1,
        K_DONE = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    typedef enum logic [5:0] {
        PH_OPEN  = 6'b000001,
        PH_BODY  = 6'b000010,
        PH_QUOTE = 6'b000100,
        PH_ESC   = 6'b001000,
        PH_QESC  = 6'b010000,
        PH_SKIP  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_byte;
        logic       out_run_last;
    } t_out_word;

    // One parsed byte's worth of results: held bytes to flush, then an
    // optional data byte, element end and array done, or a lone error.
    typedef struct packed {
        logic                             err;
        logic [HOLD_CNT_W-1:0]            hold_n;
        logic [HOLD_DEPTH-1:0][7:0]       hold;
        logic                             has_data;
        logic [7:0]                       data;
        logic                             has_end;
        logic                             has_done;
    } t_cmd;

    // Lower-case spelling of the dropped word, one letter per position.
    function automatic logic [7:0] null_char(input logic [HOLD_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h6E;
            2'd1:    c = 8'h75;
            default: c = 8'h6C;
        endcase
        return c;
    endfunction

endpackage

### rtl/alp_front.sv
// Front end of the array literal parser: tracks quoting, escapes and the
// null-element check, and turns each byte into a result command. Uses alp_pkg.
`timescale 1ns / 1ps

module alp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  alp_pkg::t_in_word i_item,
    output logic            o_cmd_push,
    output alp_pkg::t_cmd   o_cmd
);

    alp_pkg::t_phase r_phase, n_phase;
    logic r_open, n_open;
    logic [alp_pkg::RAW_CNT_W-1:0]  r_raw_count, n_raw_count;
    logic [alp_pkg::HOLD_CNT_W-1:0] r_hold_count, n_hold_count;
    logic r_null, n_null;
    logic r_quoted, n_quoted;
    logic [alp_pkg::HOLD_DEPTH-1:0][7:0] r_hold;

    logic [7:0] b;
    logic       last;
    logic do_raw, do_data, do_finish, do_done, do_fail, fail_last;
    logic hold_we;
    alp_pkg::t_cmd n_cmd;

    assign b    = i_item.in_byte;
    assign last = i_item.in_last;

    always_comb begin
        n_phase      = r_phase;
        n_open       = r_open;
        n_raw_count  = r_raw_count;
        n_hold_count = r_hold_count;
        n_null       = r_null;
        n_quoted     = r_quoted;
        do_raw       = 1'b0;
        do_data      = 1'b0;
        do_finish    = 1'b0;
        do_done      = 1'b0;
        do_fail      = 1'b0;
        fail_last    = 1'b0;
        hold_we      = 1'b0;
        n_cmd        = '0;

        unique case (r_phase)
            alp_pkg::PH_OPEN: begin
                if (b != alp_pkg::CH_LBRACE || last) begin
                    do_fail   = 1'b1;
                    fail_last = last;
                end else begin
                    n_phase      = alp_pkg::PH_BODY;
                    n_open       = 1'b0;
                    n_raw_count  = '0;
                    n_hold_count = '0;
                    n_null       = 1'b1;
                    n_quoted     = 1'b0;
                end
            end
            alp_pkg::PH_BODY: begin
                if (b == alp_pkg::CH_RBRACE) begin
                    if (!last) begin
                        do_fail = 1'b1;
                    end else begin
                        do_finish = r_open;
                        do_done   = 1'b1;
                        n_open    = 1'b0;
                        n_phase   = alp_pkg::PH_OPEN;
                    end
                end else begin
                    n_open = 1'b1;
                    if (b == alp_pkg::CH_COMMA) begin
                        do_finish = 1'b1;
                    end else begin
                        do_raw = 1'b1;
                        if (b == alp_pkg::CH_QUOTE) begin
                            n_quoted = 1'b1;
                            n_phase  = alp_pkg::PH_QUOTE;
                        end else if (b == alp_pkg::CH_BSLASH) begin
                            n_phase = alp_pkg::PH_ESC;
                        end else begin
                            do_data = 1'b1;
                        end
                    end
                    do_fail   = last;
                    fail_last = 1'b1;
                end
            end
            alp_pkg::PH_QUOTE: begin
                do_raw = 1'b1;
                if (b == alp_pkg::CH_QUOTE) begin
                    n_phase = alp_pkg::PH_BODY;
                end else if (b == alp_pkg::CH_BSLASH) begin
                    n_phase = alp_pkg::PH_QESC;
                end else begin
                    do_data = 1'b1;
                end
                do_fail   = last;
                fail_last = 1'b1;
            end
            alp_pkg::PH_ESC: begin
                do_raw    = 1'b1;
                do_data   = 1'b1;
                n_phase   = alp_pkg::PH_BODY;
                do_fail   = last;
                fail_last = 1'b1;
            end
            alp_pkg::PH_QESC: begin
                do_raw    = 1'b1;
                do_data   = 1'b1;
                n_phase   = alp_pkg::PH_QUOTE;
                do_fail   = last;
                fail_last = 1'b1;
            end
            alp_pkg::PH_SKIP: begin
                if (last) begin
                    n_phase = alp_pkg::PH_OPEN;
                end
            end
            default: begin
                n_phase = alp_pkg::PH_OPEN;
            end
        endcase

        // Raw text check against the dropped word; any fifth raw byte spoils it.
        if (do_raw) begin
            if (r_raw_count >= alp_pkg::RAW_CNT_W'(alp_pkg::HOLD_DEPTH) ||
                (b | alp_pkg::CASE_FOLD) !=
                    alp_pkg::null_char(r_raw_count[alp_pkg::HOLD_IDX_W-1:0])) begin
                n_null = 1'b0;
            end
            if (r_raw_count != alp_pkg::RAW_SAT) begin
                n_raw_count = r_raw_count + 1'b1;
            end
        end

        if (do_finish) begin
            if (!(r_null && r_raw_count == alp_pkg::RAW_CNT_W'(alp_pkg::HOLD_DEPTH)
                  && !r_quoted)) begin
                n_cmd.hold_n  = r_hold_count;
                n_cmd.hold    = r_hold;
                n_cmd.has_end = 1'b1;
            end
            n_raw_count  = '0;
            n_hold_count = '0;
            n_null       = 1'b1;
            n_quoted     = 1'b0;
        end

        if (do_data) begin
            if (n_null && r_hold_count < alp_pkg::HOLD_CNT_W'(alp_pkg::HOLD_DEPTH)) begin
                hold_we      = 1'b1;
                n_hold_count = r_hold_count + 1'b1;
            end else begin
                n_cmd.hold_n   = r_hold_count;
                n_cmd.hold     = r_hold;
                n_cmd.has_data = 1'b1;
                n_cmd.data     = b;
                n_hold_count   = '0;
            end
        end

        if (do_done) begin
            n_cmd.has_done = 1'b1;
        end

        // An error replaces everything else this byte would have produced.
        if (do_fail) begin
            n_cmd        = '0;
            n_cmd.err    = 1'b1;
            hold_we      = 1'b0;
            n_raw_count  = '0;
            n_hold_count = '0;
            n_null       = 1'b1;
            n_quoted     = 1'b0;
            n_open       = 1'b0;
            n_phase      = fail_last ? alp_pkg::PH_OPEN : alp_pkg::PH_SKIP;
        end
    end

    assign o_cmd      = n_cmd;
    assign o_cmd_push = i_accept &&
                        (n_cmd.err || n_cmd.has_data || n_cmd.has_end || n_cmd.has_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= alp_pkg::PH_OPEN;
            r_open       <= 1'b0;
            r_raw_count  <= '0;
            r_hold_count <= '0;
            r_null       <= 1'b1;
            r_quoted     <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_open       <= n_open;
            r_raw_count  <= n_raw_count;
            r_hold_count <= n_hold_count;
            r_null       <= n_null;
            r_quoted     <= n_quoted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && hold_we) begin
            r_hold[r_hold_count[alp_pkg::HOLD_IDX_W-1:0]] <= b;
        end
    end

endmodule

### rtl/alp_cmd_fifo.sv
// Short command queue between the parser front end and the result sequencer.
// Holds alp_pkg::t_cmd entries; uses alp_pkg.
`timescale 1ns / 1ps

module alp_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  alp_pkg::t_cmd i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output alp_pkg::t_cmd o_rdata
);

    alp_pkg::t_cmd r_mem [alp_pkg::CMD_DEPTH];
    logic [alp_pkg::CMD_PTR_W-1:0] r_wptr, r_rptr;
    logic [alp_pkg::CMD_CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == alp_pkg::CMD_CNT_W'(alp_pkg::CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == alp_pkg::CMD_PTR_W'(alp_pkg::CMD_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == alp_pkg::CMD_PTR_W'(alp_pkg::CMD_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### rtl/alp_back.sv
// Result sequencer: expands each queued command into result words in the output
// register, one per cycle while it is empty or popped. Uses alp_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "array_literal_parser_macros.svh"

module alp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  alp_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output alp_pkg::t_out_word o_result
);

    logic [alp_pkg::RES_CNT_W-1:0] r_idx;
    logic [alp_pkg::RES_CNT_W-1:0] count, tail_idx;
    logic r_out_valid;
    alp_pkg::t_out_word r_out, n_out;
    logic load, is_final;

    always_comb begin
        if (i_cmd.err) begin
            count = alp_pkg::RES_CNT_W'(1);
        end else begin
            count = alp_pkg::RES_CNT_W'(i_cmd.hold_n)
                  + alp_pkg::RES_CNT_W'(i_cmd.has_data)
                  + alp_pkg::RES_CNT_W'(i_cmd.has_end)
                  + alp_pkg::RES_CNT_W'(i_cmd.has_done);
        end
    end

    assign tail_idx = r_idx - alp_pkg::RES_CNT_W'(i_cmd.hold_n);
    assign is_final = (r_idx == count - 1'b1);

    always_comb begin
        n_out              = '0;
        n_out.out_run_last = is_final;
        if (i_cmd.err) begin
            n_out.out_kind = alp_pkg::K_ERR;
        end else if (r_idx < alp_pkg::RES_CNT_W'(i_cmd.hold_n)) begin
            n_out.out_kind = alp_pkg::K_DATA;
            n_out.out_byte = i_cmd.hold[r_idx[alp_pkg::HOLD_IDX_W-1:0]];
        end else if (tail_idx == '0 && i_cmd.has_data) begin
            n_out.out_kind = alp_pkg::K_DATA;
            n_out.out_byte = i_cmd.data;
        end else if (tail_idx == '0 && i_cmd.has_end) begin
            n_out.out_kind = alp_pkg::K_END;
        end else begin
            // Only an element end can come before the done word in the tail.
            n_out.out_kind = alp_pkg::K_DONE;
        end
    end

    assign load      = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = load && is_final;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= is_final ? '0 : r_idx + 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    `ALP_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, i_cmd_valid, r_idx < count)
    `ALP_ASSERT_IMPL(a_err_is_last, i_clk, i_rst_n, r_out_valid && r_out.out_kind == alp_pkg::K_ERR, r_out.out_run_last)
    `ALP_ASSERT_IMPL(a_marker_byte_zero, i_clk, i_rst_n, r_out_valid && r_out.out_kind != alp_pkg::K_DATA, r_out.out_byte == 8'h00)
    `ALP_ASSERT_NEXT(a_idx_restart, i_clk, i_rst_n, o_cmd_pop, r_idx == '0)

endmodule

### rtl/array_literal_parser.sv
// Array literal parser, top level: front end, command queue, result sequencer.
// Uses alp_pkg, alp_front, alp_cmd_fifo and alp_back.
//
// Takes one character of a brace-delimited array literal per cycle and
// returns element data bytes, element ends and a done or error word per
// literal. Input bytes are accepted every cycle while full is low. A byte
// yields zero to five result words; the sequencer emits one word per cycle
// while its output register is empty or popped, so a byte that flushes held
// data occupies it until its words are out, and the four-entry command queue
// absorbs such bursts before full rises. Results pass the queue, then the output register.
`timescale 1ns / 1ps

module array_literal_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  alp_pkg::t_in_word  i_item,
    output logic               empty,
    input  logic               pop,
    output alp_pkg::t_out_word o_result
);

    logic          accept;
    logic          cmd_push, cmd_full, cmd_valid, cmd_pop;
    alp_pkg::t_cmd cmd_wdata, cmd_rdata;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    alp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_wdata)
    );

    alp_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_wdata),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_rdata (cmd_rdata)
    );

    alp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_rdata),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

### test/array_literal_parser_tb.sv
// Self-checking testbench for the array literal parser: a directed table, then random literals.
// Results are checked word by word against a behavioral parser model kept in this file.
// Depends on alp_pkg and array_literal_parser from the RTL.
`timescale 1ns / 1ps

module array_literal_parser_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    // Letters of the dropped word; index 0 holds the first letter.
    localparam logic [3:0][7:0] NULL_TXT = "llun";

    // One row of directed stimulus. Where known is set, the row also states how many
    // words the byte causes and the kind of the final one.
    typedef struct packed {
        logic [7:0]     b;
        logic           last;
        logic           known;
        logic [2:0]     n;
        alp_pkg::t_kind k;
    } t_row;

    localparam int DIR_COUNT = 26;
    localparam t_row DIR_ROWS [DIR_COUNT] = '{
        '{"x",                1'b1, 1'b1, 3'd1, alp_pkg::K_ERR },  // no opening brace
        '{alp_pkg::CH_LBRACE, 1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_RBRACE, 1'b1, 1'b1, 3'd1, alp_pkg::K_DONE},  // empty array, no elements
        '{alp_pkg::CH_LBRACE, 1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{"N",                1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{"u",                1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{"L",                1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{"l",                1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_RBRACE, 1'b1, 1'b1, 3'd1, alp_pkg::K_DONE},  // mixed-case null dropped
        '{alp_pkg::CH_LBRACE, 1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{8'h00,              1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_COMMA,  1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{8'hFF,              1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_RBRACE, 1'b1, 1'b1, 3'd2, alp_pkg::K_DONE},
        '{alp_pkg::CH_LBRACE, 1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_RBRACE, 1'b0, 1'b1, 3'd1, alp_pkg::K_ERR },  // text after closing brace
        '{"a",                1'b0, 1'b1, 3'd0, alp_pkg::K_DATA},
        '{"b",                1'b1, 1'b1, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_LBRACE, 1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_QUOTE,  1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_BSLASH, 1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_COMMA,  1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_QUOTE,  1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_COMMA,  1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_BSLASH, 1'b0, 1'b0, 3'd0, alp_pkg::K_DATA},
        '{alp_pkg::CH_RBRACE, 1'b1, 1'b1, 3'd1, alp_pkg::K_ERR }   // escaped final brace
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    alp_pkg::t_in_word  i_item;
    logic               empty;
    logic               pop;
    alp_pkg::t_out_word o_result;
    t_row               cur_row;

    array_literal_parser DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Parser model state.
    alp_pkg::t_phase ps_phase;
    logic            ps_open;
    logic [2:0]      ps_raw;
    logic [7:0]      ps_hold [4];
    int              ps_hold_n;
    logic            ps_null;
    logic            ps_quoted;

    alp_pkg::t_out_word step_q [$];
    alp_pkg::t_out_word exp_words [$];
    alp_pkg::t_in_word  lit_q [$];

    int n_fail;
    int n_sent;
    int n_bytes;
    int n_words;
    int n_done;
    int n_err;
    int n_lits;
    int burst_left;
    int cycle_cnt;
    int pop_mode;
    int pop_span;
    int pop_tick;

    function automatic void report(input string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void emit(input alp_pkg::t_kind k, input logic [7:0] b);
        alp_pkg::t_out_word w;
        w.out_kind     = k;
        w.out_byte     = (k == alp_pkg::K_DATA) ? b : 8'h00;
        w.out_run_last = 1'b0;
        step_q.push_back(w);
    endfunction

    function automatic void elem_clear();
        ps_raw    = 3'd0;
        ps_hold_n = 0;
        ps_null   = 1'b1;
        ps_quoted = 1'b0;
    endfunction

    // Tracks whether the raw text of the element still spells the dropped word.
    function automatic void raw_seen(input logic [7:0] b);
        if (ps_raw >= 3'd4 || (b | alp_pkg::CASE_FOLD) != NULL_TXT[ps_raw[1:0]]) begin
            ps_null = 1'b0;
        end
        if (ps_raw < 3'd7) begin
            ps_raw++;
        end
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < ps_hold_n; i++) begin
            emit(alp_pkg::K_DATA, ps_hold[i]);
        end
        ps_hold_n = 0;
    endfunction

    function automatic void data_byte(input logic [7:0] b);
        if (ps_null && ps_hold_n < 4) begin
            ps_hold[ps_hold_n] = b;
            ps_hold_n++;
        end else begin
            flush_held();
            emit(alp_pkg::K_DATA, b);
        end
    endfunction

    function automatic void elem_finish();
        if (ps_null && ps_raw == 3'd4 && !ps_quoted) begin
            ps_hold_n = 0;
        end else begin
            flush_held();
            emit(alp_pkg::K_END, 8'h00);
        end
        elem_clear();
    endfunction

    // An error replaces whatever the byte would have produced.
    function automatic void fail(input logic l);
        step_q.delete();
        emit(alp_pkg::K_ERR, 8'h00);
        elem_clear();
        ps_open  = 1'b0;
        ps_phase = l ? alp_pkg::PH_OPEN : alp_pkg::PH_SKIP;
    endfunction

    // Runs one text byte through the parser model and queues the words it causes.
    function automatic int parse_char(input logic [7:0] b, input logic l);
        alp_pkg::t_out_word w;
        step_q.delete();
        case (ps_phase)
            alp_pkg::PH_OPEN: begin
                if (b != alp_pkg::CH_LBRACE) begin
                    fail(l);
                end else if (l) begin
                    fail(1'b1);
                end else begin
                    ps_phase = alp_pkg::PH_BODY;
                    ps_open  = 1'b0;
                    elem_clear();
                end
            end
            alp_pkg::PH_BODY: begin
                if (b == alp_pkg::CH_RBRACE) begin
                    if (!l) begin
                        fail(1'b0);
                    end else begin
                        if (ps_open) begin
                            elem_finish();
                        end
                        emit(alp_pkg::K_DONE, 8'h00);
                        ps_open  = 1'b0;
                        ps_phase = alp_pkg::PH_OPEN;
                    end
                end else begin
                    ps_open = 1'b1;
                    if (b == alp_pkg::CH_COMMA) begin
                        elem_finish();
                    end else begin
                        raw_seen(b);
                        if (b == alp_pkg::CH_QUOTE) begin
                            ps_quoted = 1'b1;
                            ps_phase  = alp_pkg::PH_QUOTE;
                        end else if (b == alp_pkg::CH_BSLASH) begin
                            ps_phase = alp_pkg::PH_ESC;
                        end else begin
                            data_byte(b);
                        end
                    end
                    if (l) begin
                        fail(1'b1);
                    end
                end
            end
            alp_pkg::PH_QUOTE: begin
                raw_seen(b);
                if (b == alp_pkg::CH_QUOTE) begin
                    ps_phase = alp_pkg::PH_BODY;
                end else if (b == alp_pkg::CH_BSLASH) begin
                    ps_phase = alp_pkg::PH_QESC;
                end else begin
                    data_byte(b);
                end
                if (l) begin
                    fail(1'b1);
                end
            end
            alp_pkg::PH_ESC, alp_pkg::PH_QESC: begin
                raw_seen(b);
                data_byte(b);
                ps_phase = (ps_phase == alp_pkg::PH_ESC) ? alp_pkg::PH_BODY
                                                         : alp_pkg::PH_QUOTE;
                if (l) begin
                    fail(1'b1);
                end
            end
            default: begin
                // Skipping the rest of a failed literal.
                if (l) begin
                    ps_phase = alp_pkg::PH_OPEN;
                end
            end
        endcase
        if (step_q.size() > 0) begin
            w = step_q[step_q.size() - 1];
            w.out_run_last = 1'b1;
            step_q[step_q.size() - 1] = w;
        end
        foreach (step_q[i]) begin
            exp_words.push_back(step_q[i]);
        end
        return step_q.size();
    endfunction

    function automatic void put_ch(input logic [7:0] b);
        alp_pkg::t_in_word w;
        w.in_byte = b;
        w.in_last = 1'b0;
        lit_q.push_back(w);
    endfunction

    // Escapes a character where it would otherwise end the quote, element or array.
    function automatic void put_esc(input logic [7:0] b, input logic quoted);
        if (b == alp_pkg::CH_BSLASH || b == alp_pkg::CH_QUOTE ||
                (!quoted && (b == alp_pkg::CH_COMMA || b == alp_pkg::CH_RBRACE))) begin
            put_ch(alp_pkg::CH_BSLASH);
        end
        put_ch(b);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("array_literal_parser_tb: FAIL");
            $finish;
        end
    end

    // Receiver: switches between steady popping, random stalls and a slow on/off pattern.
    always @(posedge i_clk) begin
        if (pop_span == 0) begin
            pop_mode = $urandom_range(0, 3);
            pop_span = $urandom_range(8, 64);
        end
        pop_span--;
        pop_tick++;
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= pop_tick[2];
        endcase
    end

    // Predicts at each accepted byte and checks each accepted result word.
    always @(posedge i_clk) begin
        int n;
        alp_pkg::t_out_word w;
        if (!i_rst_n) begin
            ps_phase = alp_pkg::PH_OPEN;
            ps_open  = 1'b0;
            elem_clear();
        end else begin
            if (pop && !empty) begin
                n_words++;
                if (exp_words.size() == 0) begin
                    report($sformatf("unexpected word: kind %0d byte %02h last %0b",
                                     o_result.out_kind, o_result.out_byte,
                                     o_result.out_run_last));
                end else begin
                    w = exp_words.pop_front();
                    if (o_result.out_kind !== w.out_kind || o_result.out_byte !== w.out_byte
                            || o_result.out_run_last !== w.out_run_last) begin
                        report($sformatf({"word mismatch: expected kind %0d byte %02h last %0b,",
                                          " got kind %0d byte %02h last %0b"},
                                         w.out_kind, w.out_byte, w.out_run_last,
                                         o_result.out_kind, o_result.out_byte,
                                         o_result.out_run_last));
                    end
                    if (w.out_kind == alp_pkg::K_DONE) begin
                        n_done++;
                    end else if (w.out_kind == alp_pkg::K_ERR) begin
                        n_err++;
                    end
                end
            end
            if (push && !full) begin
                n_bytes++;
                n = parse_char(i_item.in_byte, i_item.in_last);
                if (cur_row.known && (n != cur_row.n
                        || (n > 0 && step_q[n - 1].out_kind != cur_row.k))) begin
                    report($sformatf({"table row %02h: expected %0d words ending in kind %0d,",
                                      " model gives %0d"},
                                     cur_row.b, cur_row.n, cur_row.k, n));
                end
            end
        end
    end

    task automatic send_word(input alp_pkg::t_in_word w, input t_row note);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push    <= 1'b1;
        i_item  <= w;
        cur_row <= note;
        do @(posedge i_clk); while (full);
        n_sent++;
    endtask

    // Holds the input off until every predicted word has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (exp_words.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        alp_pkg::t_in_word w;
        t_row              no_row;
        int                n_elem;
        int                len;
        int                variant;
        int                k;
        logic [7:0]        c;

        no_row  = '0;
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_item  <= '0;
        cur_row <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_COUNT; i++) begin
            w.in_byte = DIR_ROWS[i].b;
            w.in_last = DIR_ROWS[i].last;
            send_word(w, DIR_ROWS[i]);
        end
        wait_drained();

        // Mostly well-formed literals with random elements; some are then broken.
        while (n_sent < DIR_COUNT + RANDOM_ITEMS) begin
            lit_q.delete();
            n_lits++;
            put_ch(alp_pkg::CH_LBRACE);
            n_elem = $urandom_range(0, 4);
            for (int e = 0; e < n_elem; e++) begin
                if (e > 0) begin
                    put_ch(alp_pkg::CH_COMMA);
                end
                case ($urandom_range(0, 5))
                    0: ;  // an empty element still counts
                    1, 2: begin
                        // The word null in random case, either exact or spoiled by
                        // a missing letter, quotes, an escape, a wrong or extra letter.
                        variant = $urandom_range(0, 5);
                        if (variant == 2) begin
                            put_ch(alp_pkg::CH_QUOTE);
                        end
                        if (variant == 3) begin
                            put_ch(alp_pkg::CH_BSLASH);
                        end
                        for (int j = 0; j < 4; j++) begin
                            c = NULL_TXT[j] ^ ($urandom_range(0, 1) ? alp_pkg::CASE_FOLD
                                                                    : 8'h00);
                            if (variant == 4 && j == 3) begin
                                c = 8'($urandom_range(0, 255));
                            end
                            if (!(variant == 1 && j == 3)) begin
                                put_esc(c, variant == 2);
                            end
                        end
                        if (variant == 2) begin
                            put_ch(alp_pkg::CH_QUOTE);
                        end
                        if (variant == 5) begin
                            put_esc(8'($urandom_range(0, 255)), 1'b0);
                        end
                    end
                    3, 4: begin
                        len = $urandom_range(1, 10);
                        for (int j = 0; j < len; j++) begin
                            put_esc(8'($urandom_range(0, 255)), 1'b0);
                        end
                    end
                    default: begin
                        if ($urandom_range(0, 1)) begin
                            put_esc(8'($urandom_range(0, 255)), 1'b0);
                        end
                        put_ch(alp_pkg::CH_QUOTE);
                        len = $urandom_range(0, 6);
                        for (int j = 0; j < len; j++) begin
                            put_esc(8'($urandom_range(0, 255)), 1'b1);
                        end
                        put_ch(alp_pkg::CH_QUOTE);
                        if ($urandom_range(0, 1)) begin
                            put_esc(8'($urandom_range(0, 255)), 1'b0);
                        end
                    end
                endcase
            end
            put_ch(alp_pkg::CH_RBRACE);

            case ($urandom_range(0, 9))
                6: begin
                    // Cut short anywhere, possibly inside a quote or an escape.
                    k = $urandom_range(1, lit_q.size() - 1);
                    while (lit_q.size() > k) begin
                        void'(lit_q.pop_back());
                    end
                end
                7: begin
                    len = $urandom_range(1, 3);
                    for (int j = 0; j < len; j++) begin
                        put_ch(8'($urandom_range(0, 255)));
                    end
                end
                8: begin
                    lit_q[0] = '{in_byte: 8'($urandom_range(0, 255)), in_last: 1'b0};
                end
                9: begin
                    lit_q.insert(lit_q.size() - 1,
                                 '{in_byte: alp_pkg::CH_BSLASH, in_last: 1'b0});
                end
                default: ;
            endcase
            w = lit_q[lit_q.size() - 1];
            w.in_last = 1'b1;
            lit_q[lit_q.size() - 1] = w;

            foreach (lit_q[i]) begin
                send_word(lit_q[i], no_row);
            end
            if ($urandom_range(0, 15) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d text bytes (%0d random literals), checked %0d result words.",
                 n_bytes, n_lits, n_words);
        $display("Literals closed cleanly: %0d, rejected with an error: %0d.", n_done, n_err);
        if (n_fail == 0) begin
            $display("array_literal_parser_tb: PASS");
        end else begin
            $display("array_literal_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
